>>> sv/lcd_mode_line_timing_fsm_macros.svh
// Assertion helpers shared by the LCD timing block.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef LCD_MODE_LINE_TIMING_FSM_MACROS_SVH
`define LCD_MODE_LINE_TIMING_FSM_MACROS_SVH

// A property that must hold at every sampled edge out of reset.
`define LMLT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define LMLT_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cause) |=> (effect)) else $error(msg);

`endif

>>> sv/lmlt_pkg.sv
`default_nettype none

package lmlt_pkg;

	// LCD controller modes, encoded as they appear in the status byte.
	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	// Frame geometry.
	localparam logic [7:0] VISIBLE_LINES = 8'd144;
	localparam logic [8:0] LAST_LINE     = 9'd153;

	// Length of each mode in machine cycles.
	localparam logic [9:0] CYC_OAM    = 10'd80;
	localparam logic [9:0] CYC_XFER   = 10'd172;
	localparam logic [9:0] CYC_HBLANK = 10'd204;
	localparam logic [9:0] CYC_LINE   = 10'd456;

	// Register settings seen by the timing core.
	typedef struct packed {
		logic [7:0] line_compare;
		logic       coincidence_irq_enable;
		logic       tiles_only;
	} cfg_t;

	// One result, first field in the highest bits.
	typedef struct packed {
		logic       oam_access_ok;
		logic       vram_access_ok;
		logic       frame_draw;
		logic       render_line;
		logic       coincidence_irq;
		logic       vblank_irq;
		logic [7:0] status_byte;
		logic [7:0] line;
		logic [1:0] mode;
	} result_t;

endpackage

`default_nettype wire

>>> sv/lmlt_cfg.sv
`default_nettype none

module lmlt_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output lmlt_pkg::cfg_t    cfg
);
	import lmlt_pkg::*;

	localparam logic [1:0] REG_LINE_COMPARE = 2'd0;
	localparam logic [1:0] REG_COIN_ENABLE  = 2'd1;
	localparam logic [1:0] REG_TILES_ONLY   = 2'd2;

	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes; an address past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LINE_COMPARE: cfg_q.line_compare <= pwdata[7:0];
				REG_COIN_ENABLE:  cfg_q.coincidence_irq_enable <= pwdata[0];
				REG_TILES_ONLY:   cfg_q.tiles_only <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back, zero extended.
	always_comb begin
		unique case (reg_idx)
			REG_LINE_COMPARE: prdata = {24'd0, cfg_q.line_compare};
			REG_COIN_ENABLE:  prdata = {31'd0, cfg_q.coincidence_irq_enable};
			REG_TILES_ONLY:   prdata = {31'd0, cfg_q.tiles_only};
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/lmlt_core.sv
`default_nettype none

module lmlt_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step_en,
	input  wire logic [7:0]    cycles,
	input  wire lmlt_pkg::cfg_t cfg,
	output lmlt_pkg::result_t  result
);
	import lmlt_pkg::*;

	mode_t      mode_q, mode_n;
	logic [7:0] line_q, line_n;
	logic [9:0] count_q, count_n;
	logic       seen_q, seen_n;
	logic [9:0] sum;
	logic [7:0] line_inc;
	logic [8:0] line_wide;
	logic       vbl_enter;
	logic       hbl_enter;
	logic       coin;

	assign sum       = count_q + {2'd0, cycles};
	assign line_inc  = line_q + 8'd1;
	assign line_wide = {1'b0, line_q} + 9'd1;

	// Next state: at most one mode change per step, surplus cycles dropped.
	always_comb begin
		mode_n    = mode_q;
		line_n    = line_q;
		count_n   = sum;
		seen_n    = seen_q;
		vbl_enter = 1'b0;
		hbl_enter = 1'b0;
		unique case (mode_q)
			MODE_HBLANK: begin
				if (sum >= CYC_HBLANK) begin
					count_n = '0;
					line_n  = line_inc;
					if (line_inc == VISIBLE_LINES) begin
						mode_n    = MODE_VBLANK;
						seen_n    = 1'b1;
						vbl_enter = 1'b1;
					end else begin
						mode_n = MODE_OAM;
					end
				end
			end
			MODE_VBLANK: begin
				if (sum >= CYC_LINE) begin
					count_n = '0;
					if (line_wide > LAST_LINE) begin
						mode_n = MODE_OAM;
						line_n = '0;
					end else begin
						line_n = line_wide[7:0];
					end
				end
			end
			MODE_OAM: begin
				if (sum >= CYC_OAM) begin
					count_n = '0;
					mode_n  = MODE_XFER;
				end
			end
			MODE_XFER: begin
				if (sum >= CYC_XFER) begin
					count_n   = '0;
					mode_n    = MODE_HBLANK;
					hbl_enter = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Result fields, all taken from the state after the step.
	always_comb begin
		coin                   = (line_n == cfg.line_compare);
		result.mode            = mode_n;
		result.line            = line_n;
		result.status_byte     = {1'b0, cfg.coincidence_irq_enable, 1'b0, seen_n,
			1'b0, coin, mode_n};
		result.vblank_irq      = vbl_enter;
		result.coincidence_irq = coin && cfg.coincidence_irq_enable;
		result.render_line     = hbl_enter && !cfg.tiles_only;
		result.frame_draw      = vbl_enter && cfg.tiles_only;
		result.vram_access_ok  = (mode_n != MODE_XFER);
		result.oam_access_ok   = !(mode_n == MODE_OAM || mode_n == MODE_XFER);
	end

	// Timing state advances once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_OAM;
			line_q  <= '0;
			count_q <= '0;
			seen_q  <= 1'b0;
		end else if (step_en) begin
			mode_q  <= mode_n;
			line_q  <= line_n;
			count_q <= count_n;
			seen_q  <= seen_n;
		end
	end

endmodule

`default_nettype wire

>>> sv/lcd_mode_line_timing_fsm.sv
// Channel   Direction  Payload
// s_*       in         cycles (8 bits)
// m_*       out        mode, line, status byte, requests, access flags (24 bits)
// APB       in/out     line_compare, coincidence_irq_enable, tiles_only
//
// One request is taken every clock while s_tready is high. An accepted request
// waits in the input register and moves on into the result register when the
// result slot is free; its result is offered from there.
// arst_n clears the timing state, the configuration registers and both valid flags.
// A stalled result holds; the input register keeps filling behind it and
// s_tready drops only when both registers are full and m_tready is low.
`default_nettype none
`include "lcd_mode_line_timing_fsm_macros.svh"

module lcd_mode_line_timing_fsm (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] cycles
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] mode, [9:2] line, [17:10] status_byte, [18] vblank_irq,
	// [19] coincidence_irq, [20] render_line, [21] frame_draw,
	// [22] vram_access_ok, [23] oam_access_ok
	output logic [23:0]      m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import lmlt_pkg::*;

	cfg_t       cfg;
	result_t    result;
	result_t    result_q;
	logic [7:0] cycles_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic       advance;
	logic       s_accept;

	lmlt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lmlt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.cycles  (cycles_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Handshake: the staged request moves on whenever the result slot frees up.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cycles_s1 <= s_tdata;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	// Checks on the result stream and the handoff between stages.
	`LMLT_ASSERT(a_vbl_at_first_blank_line, !(m_tvalid && result_q.vblank_irq) ||
		(result_q.mode == MODE_VBLANK && result_q.line == VISIBLE_LINES),
		"vblank request without entering vblank at the first blank line")
	`LMLT_ASSERT(a_render_in_hblank, !(m_tvalid && result_q.render_line) ||
		(result_q.mode == MODE_HBLANK && !result_q.frame_draw),
		"render request outside hblank")
	`LMLT_ASSERT(a_status_mode, !m_tvalid ||
		(result_q.status_byte[1:0] == result_q.mode &&
		result_q.vram_access_ok == (result_q.mode != MODE_XFER)),
		"status byte or access flag disagrees with mode")
	`LMLT_ASSERT_NEXT(a_step_lands, advance, m_tvalid,
		"a stepped request did not reach the result register")

endmodule

`default_nettype wire

>>> dv/lcd_mode_line_timing_fsm_tb.sv
`timescale 1ns / 1ps

module lcd_mode_line_timing_fsm_tb;
	import lmlt_pkg::*;

	// Register indexes; each register sits at byte address 4 * index.
	localparam int REG_LINE_COMPARE = 0;
	localparam int REG_IRQ_ENABLE   = 1;
	localparam int REG_TILES_ONLY   = 2;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [7:0] cycles
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [1:0] mode, [9:2] line, [17:10] status_byte, [18] vblank_irq,
	// [19] coincidence_irq, [20] render_line, [21] frame_draw,
	// [22] vram_access_ok, [23] oam_access_ok
	logic [23:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	lcd_mode_line_timing_fsm DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Register shadows and the timing state tracked alongside the block.
	logic [7:0] cfg_line_compare = 8'd0;
	logic       cfg_irq_enable = 1'b0;
	logic       cfg_tiles_only = 1'b0;
	mode_t      tl_mode = MODE_OAM;
	logic [7:0] tl_line = 8'd0;
	logic [9:0] tl_count = 10'd0;
	logic       tl_vblank_seen = 1'b0;

	byte unsigned cycle_queue[$];
	result_t      expected_results[$];
	logic [31:0]  readback_value = 32'd0;
	logic         req_taken = 1'b0;
	int           error_count = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           rx_cycle = 0;
	int           hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Advance the mode/line timing by one request and build the result it causes.
	function automatic result_t lcd_timing_advance(input logic [7:0] cycles);
		result_t    r;
		logic       vbl_irq;
		logic       render;
		logic       frame;
		logic       match;
		logic [8:0] next_line;
		vbl_irq = 1'b0;
		render = 1'b0;
		frame = 1'b0;
		tl_count = tl_count + {2'b00, cycles};
		case (tl_mode)
			MODE_HBLANK: begin
				if (tl_count >= CYC_HBLANK) begin
					tl_count = 10'd0;
					tl_line = tl_line + 8'd1;
					if (tl_line == VISIBLE_LINES) begin
						tl_mode = MODE_VBLANK;
						tl_vblank_seen = 1'b1;
						vbl_irq = 1'b1;
						frame = cfg_tiles_only;
					end else begin
						tl_mode = MODE_OAM;
					end
				end
			end
			MODE_VBLANK: begin
				if (tl_count >= CYC_LINE) begin
					tl_count = 10'd0;
					next_line = {1'b0, tl_line} + 9'd1;
					if (next_line > LAST_LINE) begin
						tl_mode = MODE_OAM;
						tl_line = 8'd0;
					end else begin
						tl_line = next_line[7:0];
					end
				end
			end
			MODE_OAM: begin
				if (tl_count >= CYC_OAM) begin
					tl_count = 10'd0;
					tl_mode = MODE_XFER;
				end
			end
			default: begin
				if (tl_count >= CYC_XFER) begin
					tl_count = 10'd0;
					tl_mode = MODE_HBLANK;
					render = !cfg_tiles_only;
				end
			end
		endcase
		match = (tl_line == cfg_line_compare);
		r.mode = tl_mode;
		r.line = tl_line;
		r.status_byte = {1'b0, cfg_irq_enable, 1'b0, tl_vblank_seen, 1'b0, match, tl_mode};
		r.vblank_irq = vbl_irq;
		r.coincidence_irq = match & cfg_irq_enable;
		r.render_line = render;
		r.frame_draw = frame;
		r.vram_access_ok = (tl_mode != MODE_XFER);
		r.oam_access_ok = (tl_mode != MODE_OAM) && (tl_mode != MODE_XFER);
		return r;
	endfunction

	function automatic void check_field(input string name, input int exp_val,
			input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
			error_count++;
		end
	endfunction

	// Mostly long steps so that the frame gets through all lines; some noise.
	function automatic byte unsigned random_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 78)
			return byte'($urandom_range(204, 255));
		else if (pick < 90)
			return byte'($urandom_range(0, 255));
		else
			return byte'($urandom_range(0, 15));
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin : request_driver
		logic       nxt_valid;
		logic [7:0] nxt_data;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			nxt_valid = 1'b0;
			nxt_data = s_tdata;
			if (gap_left > 0) begin
				gap_left--;
			end else if (cycle_queue.size() > 0) begin
				nxt_data = cycle_queue.pop_front();
				nxt_valid = 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			s_tvalid <= nxt_valid;
			s_tdata <= nxt_data;
		end
	end

	// Receiver: a stall pattern that rotates through four settings, plus a long
	// hold-off now and then so the block fills up and stalls its input.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_cycle % 600 == 200) begin
				hold_left = 48;
				m_tready <= 1'b0;
			end else begin
				case ((rx_cycle / 64) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (rx_cycle % 8 != 5);
				endcase
			end
		end
	end

	// Monitor: predict on each accepted request, check each accepted result and APB read.
	always @(posedge clk) begin : result_monitor
		result_t got;
		result_t want;
		req_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_results.push_back(lcd_timing_advance(s_tdata));
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					$error("unexpected result: m_tdata 0x%06h", m_tdata);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("mode", want.mode, got.mode);
					check_field("line", want.line, got.line);
					check_field("status_byte", want.status_byte, got.status_byte);
					check_field("vblank_irq", want.vblank_irq, got.vblank_irq);
					check_field("coincidence_irq", want.coincidence_irq,
						got.coincidence_irq);
					check_field("render_line", want.render_line, got.render_line);
					check_field("frame_draw", want.frame_draw, got.frame_draw);
					check_field("vram_access_ok", want.vram_access_ok,
						got.vram_access_ok);
					check_field("oam_access_ok", want.oam_access_ok, got.oam_access_ok);
				end
			end
			if (psel && penable && !pwrite && pready)
				check_field("prdata", readback_value, prdata);
		end
	end

	task automatic apb_access(input logic is_write, input int index,
			input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = is_write;
		paddr = 4'(4 * index);
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Write a register, update its shadow and read it back.
	task automatic write_register(input int index, input logic [31:0] data);
		apb_access(1'b1, index, data);
		case (index)
			REG_LINE_COMPARE: cfg_line_compare = data[7:0];
			REG_IRQ_ENABLE:   cfg_irq_enable = data[0];
			REG_TILES_ONLY:   cfg_tiles_only = data[0];
			default: ;
		endcase
		readback_value = data;
		apb_access(1'b0, index, 32'd0);
	endtask

	task automatic set_timing_config(input logic [7:0] line_compare,
			input logic irq_enable, input logic tiles_only);
		write_register(REG_LINE_COMPARE, {24'd0, line_compare});
		write_register(REG_IRQ_ENABLE, {31'd0, irq_enable});
		write_register(REG_TILES_ONLY, {31'd0, tiles_only});
	endtask

	// Block until every queued request has gone in and every result has come out.
	task automatic wait_drained();
		while (cycle_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	initial begin : stimulus
		byte unsigned directed_cycles[18];
		directed_cycles = '{8'd1, 8'd171, 8'd1, 8'd203, 8'd1, 8'd255, 8'd255, 8'd255,
			8'd128, 8'd128, 8'd0, 8'd255, 8'd255, 8'd255, 8'd79, 8'd1, 8'd255, 8'd255};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A couple of requests with the reset register values, short of the
		// OAM scan length.
		cycle_queue.push_back(8'd0);
		cycle_queue.push_back(8'd79);
		wait_drained();

		// Exact mode boundaries, full-range steps and dropped surplus cycles.
		set_timing_config(8'd1, 1'b1, 1'b0);
		foreach (directed_cycles[i])
			cycle_queue.push_back(directed_cycles[i]);
		wait_drained();

		// Random phases; the frame runs on across them.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_timing_config(8'($urandom_range(2, 143)), 1'b1, 1'b0);
				1: set_timing_config(8'd255, 1'b0, 1'b1);
				2: set_timing_config(8'd153, 1'b1, 1'b1);
				default: set_timing_config(8'd0, 1'b1, 1'b0);
			endcase
			repeat (275)
				cycle_queue.push_back(random_cycles());
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
